FILE: hdl/sslpd_pkg.sv
// Package: payload types, register map and reset values for the LED pattern driver.
package sslpd_pkg;

  localparam int unsigned TimeWidthDefault = 32;
  localparam int unsigned CfgWidth         = 16;
  localparam int unsigned CfgIndexWidth    = 3;

  localparam logic [CfgWidth-1:0] BlinkHalfPeriodReset = 16'd500;
  localparam logic [CfgWidth-1:0] PairAOnReset         = 16'd100;
  localparam logic [CfgWidth-1:0] PairAOffReset        = 16'd500;
  localparam logic [CfgWidth-1:0] PairBHalfPeriodReset = 16'd300;
  localparam logic [CfgWidth-1:0] ChaseStepReset       = 16'd500;
  localparam logic [CfgWidth-1:0] HeartbeatOnReset     = 16'd100;
  localparam logic [CfgWidth-1:0] HeartbeatOffReset    = 16'd1900;

  typedef enum logic [CfgIndexWidth-1:0] {
    REG_BLINK_HALF_PERIOD  = 3'd0,
    REG_PAIR_A_ON          = 3'd1,
    REG_PAIR_A_OFF         = 3'd2,
    REG_PAIR_B_HALF_PERIOD = 3'd3,
    REG_CHASE_STEP         = 3'd4,
    REG_HEARTBEAT_ON       = 3'd5,
    REG_HEARTBEAT_OFF      = 3'd6
  } cfg_reg_e;

  typedef enum logic [1:0] {
    MODE_BLINK  = 2'd0,
    MODE_PAIRS  = 2'd1,
    MODE_CHASE  = 2'd2,
    MODE_ALL_ON = 2'd3
  } mode_e;

  typedef struct packed {
    logic [31:0] now_ms;
    logic        switch_one_level;
    logic        switch_two_level;
  } in_t;

  typedef struct packed {
    logic [3:0] led_lit;
    logic       heartbeat_lit;
    logic [1:0] active_mode;
  } out_t;

  typedef struct packed {
    logic [CfgWidth-1:0] blink_half_period_ms;
    logic [CfgWidth-1:0] pair_a_on_ms;
    logic [CfgWidth-1:0] pair_a_off_ms;
    logic [CfgWidth-1:0] pair_b_half_period_ms;
    logic [CfgWidth-1:0] chase_step_ms;
    logic [CfgWidth-1:0] heartbeat_on_ms;
    logic [CfgWidth-1:0] heartbeat_off_ms;
  } cfg_t;

endpackage

FILE: hdl/sslpd_cfg_regs.sv
// Configuration register file for the LED pattern driver.
module sslpd_cfg_regs import sslpd_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgIndexWidth-1:0] cfg_index_i,
  input  logic [CfgWidth-1:0]      cfg_data_i,
  output cfg_t                     cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_BLINK_HALF_PERIOD:  cfg_d.blink_half_period_ms  = cfg_data_i;
        REG_PAIR_A_ON:          cfg_d.pair_a_on_ms          = cfg_data_i;
        REG_PAIR_A_OFF:         cfg_d.pair_a_off_ms         = cfg_data_i;
        REG_PAIR_B_HALF_PERIOD: cfg_d.pair_b_half_period_ms = cfg_data_i;
        REG_CHASE_STEP:         cfg_d.chase_step_ms         = cfg_data_i;
        REG_HEARTBEAT_ON:       cfg_d.heartbeat_on_ms       = cfg_data_i;
        REG_HEARTBEAT_OFF:      cfg_d.heartbeat_off_ms      = cfg_data_i;
        default:                cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.blink_half_period_ms  <= BlinkHalfPeriodReset;
      cfg_q.pair_a_on_ms          <= PairAOnReset;
      cfg_q.pair_a_off_ms         <= PairAOffReset;
      cfg_q.pair_b_half_period_ms <= PairBHalfPeriodReset;
      cfg_q.chase_step_ms         <= ChaseStepReset;
      cfg_q.heartbeat_on_ms       <= HeartbeatOnReset;
      cfg_q.heartbeat_off_ms      <= HeartbeatOffReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hdl/sslpd_core.sv
// Pattern state and next-state logic: mode decode, interval timers, LED and heartbeat updates.
module sslpd_core import sslpd_pkg::*; #(
  parameter int unsigned TIME_WIDTH = TimeWidthDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic step_i,
  input  in_t  item_i,
  input  cfg_t cfg_i,
  output out_t result_o
);

  logic [1:0]            prev_mode_q, prev_mode_d;
  logic [3:0]            dark_q, dark_d;
  logic                  phase_q, phase_d;
  logic [1:0]            chase_q, chase_d;
  logic                  hb_dark_q, hb_dark_d;
  logic [TIME_WIDTH-1:0] blink_stamp_q, blink_stamp_d;
  logic [TIME_WIDTH-1:0] pair_a_stamp_q, pair_a_stamp_d;
  logic [TIME_WIDTH-1:0] pair_b_stamp_q, pair_b_stamp_d;
  logic [TIME_WIDTH-1:0] chase_stamp_q, chase_stamp_d;
  logic [TIME_WIDTH-1:0] hb_stamp_q, hb_stamp_d;

  logic [63:0]           now_ext;
  logic [TIME_WIDTH-1:0] now_t;
  logic [1:0]            mode;
  logic                  changed;
  logic [CfgWidth-1:0]   pair_a_lim, hb_lim;
  logic                  blink_exp, pair_a_exp, pair_b_exp, chase_exp, hb_exp;

  function automatic logic expired(input logic [TIME_WIDTH-1:0] now,
                                   input logic [TIME_WIDTH-1:0] stamp,
                                   input logic [CfgWidth-1:0]   lim);
    logic [TIME_WIDTH-1:0] elapsed;
    logic [63:0]           lim_ext;
    elapsed = now - stamp;
    lim_ext = {{(64-CfgWidth){1'b0}}, lim};
    return elapsed >= lim_ext[TIME_WIDTH-1:0];
  endfunction

  assign now_ext = {32'b0, item_i.now_ms};
  assign now_t   = now_ext[TIME_WIDTH-1:0];
  assign mode    = {~item_i.switch_two_level, ~item_i.switch_one_level};
  assign changed = (mode != prev_mode_q);

  always_comb begin
    prev_mode_d    = mode;
    dark_d         = changed ? 4'hF : dark_q;
    phase_d        = changed ? 1'b0 : phase_q;
    chase_d        = changed ? 2'd0 : chase_q;
    blink_stamp_d  = blink_stamp_q;
    pair_a_stamp_d = pair_a_stamp_q;
    pair_b_stamp_d = pair_b_stamp_q;
    chase_stamp_d  = chase_stamp_q;
    hb_stamp_d     = hb_stamp_q;
    hb_dark_d      = hb_dark_q;

    pair_a_lim = dark_d[0] ? cfg_i.pair_a_off_ms : cfg_i.pair_a_on_ms;
    hb_lim     = hb_dark_q ? cfg_i.heartbeat_off_ms : cfg_i.heartbeat_on_ms;
    blink_exp  = expired(now_t, blink_stamp_q, cfg_i.blink_half_period_ms);
    pair_a_exp = expired(now_t, pair_a_stamp_q, pair_a_lim);
    pair_b_exp = expired(now_t, pair_b_stamp_q, cfg_i.pair_b_half_period_ms);
    chase_exp  = expired(now_t, chase_stamp_q, cfg_i.chase_step_ms);
    hb_exp     = expired(now_t, hb_stamp_q, hb_lim);

    case (mode)
      MODE_BLINK: begin
        if (blink_exp) begin
          phase_d       = ~phase_d;
          dark_d        = phase_d ? 4'hF : 4'h0;
          blink_stamp_d = now_t;
        end
      end
      MODE_PAIRS: begin
        if (pair_a_exp) begin
          dark_d[0]      = ~dark_d[0];
          dark_d[2]      = dark_d[0];
          pair_a_stamp_d = now_t;
        end
        if (pair_b_exp) begin
          dark_d         = dark_d ^ 4'hA;
          pair_b_stamp_d = now_t;
        end
      end
      MODE_CHASE: begin
        if (chase_exp) begin
          dark_d        = ~(4'b0001 << chase_d);
          chase_d       = chase_d + 2'd1;
          chase_stamp_d = now_t;
        end
      end
      default: begin
        dark_d = 4'h0;
      end
    endcase

    if (hb_exp) begin
      hb_dark_d  = ~hb_dark_q;
      hb_stamp_d = now_t;
    end

    result_o.led_lit       = ~dark_d;
    result_o.heartbeat_lit = ~hb_dark_d;
    result_o.active_mode   = mode;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_mode_q    <= MODE_BLINK;
      dark_q         <= 4'hF;
      phase_q        <= 1'b0;
      chase_q        <= 2'd0;
      hb_dark_q      <= 1'b1;
      blink_stamp_q  <= '0;
      pair_a_stamp_q <= '0;
      pair_b_stamp_q <= '0;
      chase_stamp_q  <= '0;
      hb_stamp_q     <= '0;
    end else if (step_i) begin
      prev_mode_q    <= prev_mode_d;
      dark_q         <= dark_d;
      phase_q        <= phase_d;
      chase_q        <= chase_d;
      hb_dark_q      <= hb_dark_d;
      blink_stamp_q  <= blink_stamp_d;
      pair_a_stamp_q <= pair_a_stamp_d;
      pair_b_stamp_q <= pair_b_stamp_d;
      chase_stamp_q  <= chase_stamp_d;
      hb_stamp_q     <= hb_stamp_d;
    end
  end

endmodule

FILE: hdl/switch_selected_led_pattern_driver_top.sv
// Top level of the switch-selected LED pattern driver: input register, core and result register.
// Each input beat is one pass of the control loop and yields exactly one result beat. A beat is
// taken into the input register, then processed by the core as it moves into the result
// register, which presents its result until it is taken.
// One beat per cycle is sustained as long as results are taken; the input side stalls only when
// both the input register and the result register hold beats and out_ready_i is low.
// Configuration writes are accepted every cycle and take effect on the next processed beat.
module switch_selected_led_pattern_driver_top import sslpd_pkg::*; #(
  parameter int unsigned TIME_WIDTH = TimeWidthDefault
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  in_t                      in_data_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output out_t                     out_data_o,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CfgIndexWidth-1:0] cfg_index_i,
  input  logic [CfgWidth-1:0]      cfg_data_i
);

  cfg_t cfg;
  in_t  in_q;
  out_t out_q, result;
  logic in_valid_q, out_valid_q;
  logic advance;

  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  sslpd_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  sslpd_core #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (in_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (advance) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_q |-> in_ready_o)
    else $error("input stalled with empty result register");

  a_advance_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("processed beat lost");

  a_all_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.active_mode == MODE_ALL_ON) |-> out_q.led_lit == 4'hF)
    else $error("all-on mode with dark LED");

  a_chase_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.active_mode == MODE_CHASE) |-> $onehot0(out_q.led_lit))
    else $error("chase mode lights more than one LED");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// Testbench for the switch-selected LED pattern driver: directed and random passes checked against a predictor.
module testbench;
  import sslpd_pkg::*;

  localparam int NumCfgRegs = 7;
  localparam logic [CfgIndexWidth-1:0] UnusedRegIndex = CfgIndexWidth'(NumCfgRegs);

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  in_t                      in_beat = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  out_t                     out_beat;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CfgIndexWidth-1:0] cfg_index = '0;
  logic [CfgWidth-1:0]      cfg_data = '0;

  switch_selected_led_pattern_driver_top i_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_beat),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_beat),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always #1 clk = ~clk;

  // predictor state
  logic [CfgWidth-1:0] period_regs [NumCfgRegs];
  mode_e       last_mode;
  logic [3:0]  dark_mask;
  logic        blink_dark_phase;
  logic [1:0]  chase_next;
  logic [31:0] blink_mark, pair_a_mark, pair_b_mark, chase_mark, heartbeat_mark;
  logic        heartbeat_dark;

  out_t pending_patterns [$];
  int   passes_sent = 0;
  int   patterns_checked = 0;
  int   mismatches = 0;
  int   reg_writes = 0;
  int   settings_tried = 0;
  bit   idle_on = 1'b1;
  int   stall_left = 0;

  task automatic load_reset_state();
    period_regs[REG_BLINK_HALF_PERIOD]  = BlinkHalfPeriodReset;
    period_regs[REG_PAIR_A_ON]          = PairAOnReset;
    period_regs[REG_PAIR_A_OFF]         = PairAOffReset;
    period_regs[REG_PAIR_B_HALF_PERIOD] = PairBHalfPeriodReset;
    period_regs[REG_CHASE_STEP]         = ChaseStepReset;
    period_regs[REG_HEARTBEAT_ON]       = HeartbeatOnReset;
    period_regs[REG_HEARTBEAT_OFF]      = HeartbeatOffReset;
    last_mode        = MODE_BLINK;
    dark_mask        = 4'hF;
    blink_dark_phase = 1'b0;
    chase_next       = 2'd0;
    blink_mark       = '0;
    pair_a_mark      = '0;
    pair_b_mark      = '0;
    chase_mark       = '0;
    heartbeat_mark   = '0;
    heartbeat_dark   = 1'b1;
  endtask

  function automatic logic reached(logic [31:0] now, logic [31:0] mark, logic [15:0] limit);
    logic [31:0] span;
    span = now - mark;
    return span >= {16'h0, limit};
  endfunction

  function automatic out_t next_pattern(in_t beat);
    mode_e       mode;
    logic [31:0] now;
    out_t        res;
    now  = beat.now_ms;
    mode = mode_e'({~beat.switch_two_level, ~beat.switch_one_level});
    if (mode != last_mode) begin
      chase_next       = 2'd0;
      blink_dark_phase = 1'b0;
      dark_mask        = 4'hF;
      last_mode        = mode;
    end
    case (mode)
      MODE_BLINK: begin
        if (reached(now, blink_mark, period_regs[REG_BLINK_HALF_PERIOD])) begin
          blink_dark_phase = ~blink_dark_phase;
          dark_mask        = blink_dark_phase ? 4'hF : 4'h0;
          blink_mark       = now;
        end
      end
      MODE_PAIRS: begin
        if (dark_mask[0]) begin
          if (reached(now, pair_a_mark, period_regs[REG_PAIR_A_OFF])) begin
            dark_mask   = dark_mask & ~4'h5;
            pair_a_mark = now;
          end
        end else begin
          if (reached(now, pair_a_mark, period_regs[REG_PAIR_A_ON])) begin
            dark_mask   = dark_mask | 4'h5;
            pair_a_mark = now;
          end
        end
        if (reached(now, pair_b_mark, period_regs[REG_PAIR_B_HALF_PERIOD])) begin
          dark_mask   = dark_mask ^ 4'hA;
          pair_b_mark = now;
        end
      end
      MODE_CHASE: begin
        if (reached(now, chase_mark, period_regs[REG_CHASE_STEP])) begin
          dark_mask  = 4'hF & ~(4'h1 << chase_next);
          chase_next = chase_next + 2'd1;
          chase_mark = now;
        end
      end
      default: begin
        dark_mask = 4'h0;
      end
    endcase
    if (heartbeat_dark) begin
      if (reached(now, heartbeat_mark, period_regs[REG_HEARTBEAT_OFF])) begin
        heartbeat_dark = 1'b0;
        heartbeat_mark = now;
      end
    end else begin
      if (reached(now, heartbeat_mark, period_regs[REG_HEARTBEAT_ON])) begin
        heartbeat_dark = 1'b1;
        heartbeat_mark = now;
      end
    end
    res.led_lit       = ~dark_mask;
    res.heartbeat_lit = ~heartbeat_dark;
    res.active_mode   = mode;
    return res;
  endfunction

  task automatic note_mismatch(string what, out_t want, out_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: %s: expected led %h hb %b mode %0d, got led %h hb %b mode %0d", $realtime,
               what, want.led_lit, want.heartbeat_lit, want.active_mode, got.led_lit,
               got.heartbeat_lit, got.active_mode);
    end
  endtask

  // results are checked before the same edge's input beat enters the predictor
  always @(posedge clk) begin : check_results
    out_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pending_patterns.size() == 0) begin
          note_mismatch("unexpected beat", '0, out_beat);
        end else begin
          want = pending_patterns.pop_front();
          patterns_checked++;
          if (out_beat.led_lit !== want.led_lit ||
              out_beat.heartbeat_lit !== want.heartbeat_lit ||
              out_beat.active_mode !== want.active_mode) begin
            note_mismatch("field mismatch", want, out_beat);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        reg_writes++;
        if (cfg_index < NumCfgRegs) period_regs[cfg_index] = cfg_data;
      end
      if (in_valid && in_ready) begin
        passes_sent++;
        pending_patterns.push_back(next_pattern(in_beat));
      end
    end
  end

  function automatic int pick_stall_len();
    if ($urandom_range(99) < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  always @(negedge clk) begin
    if (!idle_on) begin
      out_ready = 1'b1;
    end else if (stall_left > 0) begin
      out_ready = 1'b0;
      stall_left--;
    end else begin
      out_ready = 1'b1;
      if ($urandom_range(99) < 20) stall_left = pick_stall_len();
    end
  end

  // entered and left at a falling edge; valid stays high after the beat when no gap follows
  task automatic send_pass(in_t item);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(99) >= 60) gap = pick_stall_len();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_beat  = item;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_levels(logic [31:0] now, logic s1, logic s2);
    in_t item;
    item.now_ms           = now;
    item.switch_one_level = s1;
    item.switch_two_level = s2;
    send_pass(item);
  endtask

  task automatic wait_idle();
    in_valid = 1'b0;
    while (pending_patterns.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [CfgIndexWidth-1:0] idx, logic [CfgWidth-1:0] value);
    cfg_index = idx;
    cfg_data  = value;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic write_all_regs(int lo, int hi);
    wait_idle();
    settings_tried++;
    for (int i = 0; i < NumCfgRegs; i++) begin
      write_reg(CfgIndexWidth'(i), CfgWidth'($urandom_range(lo, hi)));
    end
  endtask

  // mostly steady switches and forward time, with jumps, rewinds and switch glitches
  task automatic run_random_passes(int count, int step_max);
    logic [31:0] stamp;
    logic [1:0]  levels;
    int          hold;
    int          r;
    stamp = $urandom;
    hold  = 0;
    levels = 2'b11;
    for (int n = 0; n < count; n++) begin
      if (hold == 0) begin
        levels = 2'($urandom);
        hold   = $urandom_range(1, 60);
      end
      hold--;
      r = $urandom_range(99);
      if (r < 3) stamp = $urandom;
      else if (r < 5) stamp = stamp - $urandom_range(1, step_max);
      else stamp = stamp + $urandom_range(0, step_max);
      send_levels(stamp, levels[0], levels[1]);
    end
  endtask

  task automatic test_mode_select();
    send_levels(32'd0, 1'b1, 1'b1);
    send_levels(32'd500, 1'b1, 1'b1);
    send_levels(32'd1000, 1'b1, 1'b1);
    send_levels(32'd1000, 1'b0, 1'b1);
    send_levels(32'd1600, 1'b0, 1'b1);
    send_levels(32'd1700, 1'b0, 1'b1);
    send_levels(32'd1800, 1'b1, 1'b0);
    send_levels(32'd2400, 1'b1, 1'b0);
    send_levels(32'd2900, 1'b1, 1'b0);
    send_levels(32'd2900, 1'b0, 1'b0);
    send_levels(32'hFFFF_FFFF, 1'b0, 1'b0);
    send_levels(32'h0000_0010, 1'b1, 1'b1);
    send_levels(32'h8000_0000, 1'b0, 1'b1);
    send_levels(32'h7FFF_FFFF, 1'b1, 1'b0);
  endtask

  // a zero period fires on every pass; an unused index must change nothing
  task automatic test_zero_and_unused_regs();
    wait_idle();
    write_reg(UnusedRegIndex, 16'hFFFF);
    write_reg(REG_BLINK_HALF_PERIOD, 16'd0);
    write_reg(REG_HEARTBEAT_ON, 16'd0);
    write_reg(REG_HEARTBEAT_OFF, 16'd0);
    repeat (4) send_levels(32'h1234_5678, 1'b1, 1'b1);
    send_levels(32'h1234_5678, 1'b0, 1'b1);
    send_levels(32'h1234_5679, 1'b1, 1'b1);
  endtask

  task automatic test_extreme_settings();
    write_all_regs(int'(HeartbeatOnReset), int'(HeartbeatOffReset));
    run_random_passes(300, 100);
    idle_on = 1'b0;
    write_all_regs(1, 1);
    run_random_passes(250, 2);
    idle_on = 1'b1;
    write_all_regs(0, 0);
    run_random_passes(200, 5);
    write_all_regs(65535, 65535);
    run_random_passes(250, 30000);
  endtask

  task automatic test_random_settings();
    write_all_regs(1, 65535);
    run_random_passes(350, 8000);
    write_all_regs(1, 50);
    run_random_passes(175, 20);
    idle_on = 1'b0;
    run_random_passes(175, 20);
    idle_on = 1'b1;
  endtask

  initial begin
    load_reset_state();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_mode_select();
    test_zero_and_unused_regs();
    test_extreme_settings();
    test_random_settings();
    wait_idle();
    repeat (4) @(posedge clk);
    $display("%0d passes over %0d register settings, %0d register writes", passes_sent,
             settings_tried, reg_writes);
    $display("%0d patterns checked, %0d mismatches", patterns_checked, mismatches);
    if (mismatches == 0 && pending_patterns.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("timeout with %0d patterns outstanding", pending_patterns.size());
    $display("testbench failed");
    $finish;
  end

endmodule

FILE: sim.f
hdl/sslpd_pkg.sv
hdl/sslpd_cfg_regs.sv
hdl/sslpd_core.sv
hdl/switch_selected_led_pattern_driver_top.sv
tb/testbench.sv
